// File: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker pidh_chk.
// Needs nothing else; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on the same edge
`define CHK_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// implication checked on the next edge
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

// File: rtl/core/pidh_pkg.sv
// Shared types, constants and saturating helpers for the PID heating loop.
// Used by every module of the block; depends on nothing.
package pidh_pkg;
    localparam int FRAC_BITS = 16;
    localparam logic signed [31:0] ROOM_LOSS_GAIN      = 32'sd65536;
    localparam logic signed [31:0] ROOM_SCALE_GAIN     = 32'sd65536;
    localparam logic signed [31:0] RADIATOR_SCALE_GAIN = 32'sd65536;
    localparam logic signed [31:0] FLOW_GAIN           = 32'sd65536;

    localparam logic [2:0] REG_PROP   = 3'd0;
    localparam logic [2:0] REG_INTEG  = 3'd1;
    localparam logic [2:0] REG_DERIV  = 3'd2;
    localparam logic [2:0] REG_FILTER = 3'd3;
    localparam logic [2:0] REG_STEP   = 3'd4;
    localparam logic [2:0] REG_LOWER  = 3'd5;
    localparam logic [2:0] REG_XFER   = 3'd6;

    typedef struct packed {
        logic signed [31:0] supply_temp;
        logic signed [31:0] outdoor_temp;
        logic        [30:0] flow_capacity;
        logic signed [31:0] setpoint;
    } t_in;

    typedef struct packed {
        logic signed [31:0] radiator_temp;
        logic signed [31:0] room_temp;
        logic signed [31:0] setpoint_echo;
        logic signed [31:0] drive;
    } t_out;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b,
                                                   input logic do_sub);
        logic signed [32:0] s;
        s = do_sub ? ({a[31], a} - {b[31], b}) : ({a[31], a} + {b[31], b});
        if (s[32] != s[31]) begin
            sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            sat_add = s[31:0];
        end
    endfunction
endpackage

// File: rtl/core/pid_heating_loop_with_thermal_plant.sv
// PID heating loop with a radiator/room thermal plant, Q16.16 fixed point.
// One word in gives one word out. Every step runs through one shared
// bit-serial multiplier, 17 products per item, and no new word is accepted
// while one is still in work. Depends on pidh_pkg, pidh_mul.
module pid_heating_loop_with_thermal_plant (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pidh_pkg::t_in       i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pidh_pkg::t_out      o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import pidh_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;
    localparam logic [4:0] OP_LAST  = 5'd16;

    logic [30:0] r_prop, r_integ, r_deriv, r_filter, r_step, r_xgain;
    logic signed [31:0] r_lower;
    logic signed [31:0] r_room, r_pi, r_df, r_rad;
    logic signed [31:0] r_tr, r_tp, r_p, r_dt, r_irate, r_t, r_loss, r_frate;
    logic signed [31:0] r_u, r_flow, r_xfer, r_rr, r_heat, r_radrate;
    t_in  r_in;
    t_out r_out;
    logic r_ovalid;
    logic [1:0] r_state;
    logic [4:0] r_op;
    logic signed [31:0] mul_a, mul_b, res, h, err, u_sum;
    logic mul_done, in_acc, wr;

    assign h      = {1'b0, r_step};
    assign err    = sat_add(r_in.setpoint, r_tr, 1'b1);
    assign in_acc = i_in_valid && (r_state == ST_IDLE);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[4:2])
            REG_PROP:   prdata = {1'b0, r_prop};
            REG_INTEG:  prdata = {1'b0, r_integ};
            REG_DERIV:  prdata = {1'b0, r_deriv};
            REG_FILTER: prdata = {1'b0, r_filter};
            REG_STEP:   prdata = {1'b0, r_step};
            REG_LOWER:  prdata = r_lower;
            REG_XFER:   prdata = {1'b0, r_xgain};
            default:    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop   <= 31'd65536;
            r_integ  <= 31'd0;
            r_deriv  <= 31'd0;
            r_filter <= 31'd6553600;
            r_step   <= 31'd65536;
            r_lower  <= 32'sd0;
            r_xgain  <= 31'd65536;
        end else if (wr) begin
            case (paddr[4:2])
                REG_PROP:   r_prop   <= pwdata[30:0];
                REG_INTEG:  r_integ  <= pwdata[30:0];
                REG_DERIV:  r_deriv  <= pwdata[30:0];
                REG_FILTER: r_filter <= pwdata[30:0];
                REG_STEP:   r_step   <= pwdata[30:0];
                REG_LOWER:  r_lower  <= pwdata;
                REG_XFER:   r_xgain  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (r_op)
            5'd0:    begin mul_a = {1'b0, r_prop};   mul_b = err; end
            5'd1:    begin mul_a = {1'b0, r_deriv};  mul_b = err; end
            5'd2:    begin mul_a = {1'b0, r_integ};  mul_b = err; end
            5'd3:    begin
                mul_a = sat_add(r_tr, r_in.outdoor_temp, 1'b1);
                mul_b = ROOM_LOSS_GAIN;
            end
            5'd4:    begin mul_a = r_t; mul_b = ROOM_SCALE_GAIN; end
            5'd5:    begin
                mul_a = {1'b0, r_filter};
                mul_b = sat_add(r_dt, r_df, 1'b1);
            end
            5'd6:    begin mul_a = r_u; mul_b = {1'b0, r_in.flow_capacity}; end
            5'd7:    begin mul_a = r_t; mul_b = FLOW_GAIN; end
            5'd8:    begin mul_a = sat_add(r_tp, r_tr, 1'b1); mul_b = {1'b0, r_xgain}; end
            5'd9:    begin mul_a = r_xfer; mul_b = ROOM_SCALE_GAIN; end
            5'd10:   begin mul_a = sat_add(r_in.supply_temp, r_tp, 1'b1); mul_b = r_flow; end
            5'd11:   begin mul_a = r_t; mul_b = RADIATOR_SCALE_GAIN; end
            5'd12:   begin mul_a = r_xfer; mul_b = RADIATOR_SCALE_GAIN; end
            5'd13:   begin mul_a = h; mul_b = r_rr; end
            5'd14:   begin mul_a = h; mul_b = r_irate; end
            5'd15:   begin mul_a = h; mul_b = r_frate; end
            default: begin mul_a = h; mul_b = r_radrate; end
        endcase
    end

    pidh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_ISSUE),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_res   (res)
    );

    assign u_sum = sat_add(sat_add(r_p, r_pi, 1'b0), res, 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= 5'd0;
            r_ovalid <= 1'b0;
            r_room   <= 32'sd0;
            r_pi     <= 32'sd0;
            r_df     <= 32'sd0;
            r_rad    <= 32'sd0;
        end else begin
            if (r_ovalid && !i_out_stall && r_state != ST_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= ST_ISSUE;
                        r_op    <= 5'd0;
                    end
                end
                ST_ISSUE: r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (mul_done) begin
                        r_state <= (r_op == OP_LAST) ? ST_DONE : ST_ISSUE;
                        r_op    <= r_op + 5'd1;
                        case (r_op)
                            5'd13: r_room <= sat_add(r_room, res, 1'b0);
                            5'd14: r_pi   <= sat_add(r_pi, res, 1'b0);
                            5'd15: r_df   <= sat_add(r_df, res, 1'b0);
                            5'd16: r_rad  <= sat_add(r_rad, res, 1'b0);
                            default: ;
                        endcase
                    end
                end
                default: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in;
            r_tr <= r_room;
            r_tp <= r_rad;
        end
        if (r_state == ST_WAIT && mul_done) begin
            case (r_op)
                5'd0:  r_p     <= res;
                5'd1:  r_dt    <= res;
                5'd2:  r_irate <= res;
                5'd4:  r_loss  <= res;
                5'd5: begin
                    r_frate <= res;
                    if (u_sum > h) begin
                        r_u <= h;
                    end else if (u_sum < r_lower) begin
                        r_u <= r_lower;
                    end else begin
                        r_u <= u_sum;
                    end
                end
                5'd7:  r_flow    <= res;
                5'd8:  r_xfer    <= res;
                5'd9:  r_rr      <= sat_add(res, r_loss, 1'b1);
                5'd11: r_heat    <= res;
                5'd12: r_radrate <= sat_add(r_heat, res, 1'b1);
                default: r_t     <= res;
            endcase
        end
        if (r_state == ST_DONE && (!r_ovalid || !i_out_stall)) begin
            r_out.radiator_temp <= r_tp;
            r_out.room_temp     <= r_tr;
            r_out.setpoint_echo <= r_in.setpoint;
            r_out.drive         <= r_u;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;
endmodule

// File: rtl/core/pidh_mul.sv
// Bit-serial fixed-point multiplier: one multiplier bit per cycle, floor shift
// by FRAC_BITS and 32-bit saturation. Depends on pidh_pkg.
module pidh_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic               o_done,
    output logic signed [31:0] o_res
);
    import pidh_pkg::*;

    logic signed [63:0] r_acc, r_mcand, n_sum, addend;
    logic        [31:0] r_mplier;
    logic        [4:0]  r_cnt;
    logic               r_busy, r_done;
    logic        [63-FRAC_BITS-31:0] hi;

    assign addend = r_mplier[0] ? r_mcand : 64'sd0;
    assign n_sum  = (r_cnt == 5'd31) ? (r_acc - addend) : (r_acc + addend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= 64'sd0;
            r_mcand  <= {{32{i_a[31]}}, i_a};
            r_mplier <= i_b;
        end else if (r_busy) begin
            r_acc    <= n_sum;
            r_mcand  <= r_mcand <<< 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign hi = r_acc[63:FRAC_BITS+31];

    always_comb begin
        if ((&hi) || !(|hi)) begin
            o_res = r_acc[FRAC_BITS+31:FRAC_BITS];
        end else begin
            o_res = r_acc[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
    end

    assign o_done = r_done;
endmodule

// File: rtl/core/pidh_chk.sv
// Port-level checker for the PID heating loop, bound to the top level.
// Depends on pidh_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pidh_chk (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input pidh_pkg::t_out o_out,
    input logic           pready
);
    import pidh_pkg::*;

    `CHK_SAME(a_pready, i_clk, i_rst_n, 1'b1, pready)
    `CHK_NEXT(a_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `CHK_NEXT(a_no_instant, i_clk, i_rst_n, i_in_valid && !o_in_stall, !$rose(o_out_valid))
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out))
endmodule

bind pid_heating_loop_with_thermal_plant pidh_chk u_pidh_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out),
    .pready      (pready)
);

// File: test/pidh_checker.sv
// Checker for the PID heating loop: follows register writes, predicts each
// result word from accepted input words, compares field by field.
// Depends on pidh_pkg.
`timescale 1ns / 1ps
module pidh_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  pidh_pkg::t_in  i_in,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  pidh_pkg::t_out i_out,
    input  logic           i_psel,
    input  logic           i_penable,
    input  logic           i_pwrite,
    input  logic [4:0]     i_paddr,
    input  logic [31:0]    i_pwdata,
    input  logic           i_pready,
    output int             o_errors,
    output int             o_pending,
    output int             o_results
);
    import pidh_pkg::*;

    logic signed [31:0] kp, ki, kd, nf, h, lo, kx;
    logic signed [31:0] room, integ, dfilt, rad;
    t_out               expected_q[$];

    function automatic logic signed [31:0] sat(input logic signed [63:0] v);
        if (v > 64'sh7fff_ffff) return 32'sh7fff_ffff;
        if (v < -64'sh8000_0000) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        logic signed [63:0] s;
        s = 64'(a) + 64'(b);
        return sat(s);
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        logic signed [63:0] s;
        s = 64'(a) - 64'(b);
        return sat(s);
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat(p >>> FRAC_BITS);
    endfunction

    task automatic advance_loop(input t_in w);
        logic signed [31:0] flowcap, err, pterm, dterm, irate, loss, frate, u;
        logic signed [31:0] flow, xfer, room_rate, heat_in, rad_rate;
        t_out r;
        flowcap = {1'b0, w.flow_capacity};
        err   = qsub(w.setpoint, room);
        pterm = qmul(kp, err);
        dterm = qmul(kd, err);
        irate = qmul(ki, err);
        loss  = qmul(qmul(qsub(room, w.outdoor_temp), ROOM_LOSS_GAIN), ROOM_SCALE_GAIN);
        frate = qmul(nf, qsub(dterm, dfilt));
        u = qadd(qadd(pterm, integ), frate);
        if (u > h) u = h;
        else if (u < lo) u = lo;
        flow      = qmul(qmul(u, flowcap), FLOW_GAIN);
        xfer      = qmul(qsub(rad, room), kx);
        room_rate = qsub(qmul(xfer, ROOM_SCALE_GAIN), loss);
        heat_in   = qmul(qmul(qsub(w.supply_temp, rad), flow), RADIATOR_SCALE_GAIN);
        rad_rate  = qsub(heat_in, qmul(xfer, RADIATOR_SCALE_GAIN));
        r.radiator_temp = rad;
        r.room_temp     = room;
        r.setpoint_echo = w.setpoint;
        r.drive         = u;
        expected_q.push_back(r);
        room  = qadd(room, qmul(h, room_rate));
        integ = qadd(integ, qmul(h, irate));
        dfilt = qadd(dfilt, qmul(h, frate));
        rad   = qadd(rad, qmul(h, rad_rate));
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, want %h", $time, field, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_results = 0;
    end

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_out e;
        if (!i_rst_n) begin
            kp <= 32'sd65536; ki <= 0; kd <= 0; nf <= 32'sd6553600;
            h <= 32'sd65536; lo <= 0; kx <= 32'sd65536;
            room = 0; integ = 0; dfilt = 0; rad = 0;
            expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_PROP:   kp <= {1'b0, i_pwdata[30:0]};
                    REG_INTEG:  ki <= {1'b0, i_pwdata[30:0]};
                    REG_DERIV:  kd <= {1'b0, i_pwdata[30:0]};
                    REG_FILTER: nf <= {1'b0, i_pwdata[30:0]};
                    REG_STEP:   h  <= {1'b0, i_pwdata[30:0]};
                    REG_LOWER:  lo <= i_pwdata;
                    REG_XFER:   kx <= {1'b0, i_pwdata[30:0]};
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (expected_q.size() == 0) begin
                    $display("%0t result word with nothing expected", $time);
                    o_errors++;
                end else begin
                    e = expected_q.pop_front();
                    if (i_out.radiator_temp !== e.radiator_temp)
                        report_mismatch("radiator_temp", i_out.radiator_temp, e.radiator_temp);
                    if (i_out.room_temp !== e.room_temp)
                        report_mismatch("room_temp", i_out.room_temp, e.room_temp);
                    if (i_out.setpoint_echo !== e.setpoint_echo)
                        report_mismatch("setpoint_echo", i_out.setpoint_echo, e.setpoint_echo);
                    if (i_out.drive !== e.drive)
                        report_mismatch("drive", i_out.drive, e.drive);
                end
            end
            if (i_in_valid && !i_in_stall) advance_loop(i_in);
        end
    end
endmodule

// File: test/pid_heating_loop_with_thermal_plant_tb.sv
// Testbench top for the PID heating loop: drives input words, register
// writes and output stalls, and gives the verdict from pidh_checker.
// Depends on pidh_pkg, pidh_checker and the block itself.
`timescale 1ns / 1ps
module pid_heating_loop_with_thermal_plant_tb;
    import pidh_pkg::*;

    logic        i_clk, i_rst_n;
    logic        in_valid, in_stall, out_valid, out_stall;
    t_in         in_word;
    t_out        out_word;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        in_taken;
    bit          gaps_on, hold_req;
    int          errors, pending, results, words_sent, settings_used;

    localparam int Q = 65536;

    pid_heating_loop_with_thermal_plant dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in(in_word),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out(out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    pidh_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in(in_word),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out(out_word),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) in_taken <= in_valid && !in_stall;

    initial begin
        #60_000_000;
        $display("timeout");
        $display("pid_heating_loop_with_thermal_plant_tb failed");
        $finish;
    end

    // output stall: random bursts, plus one long hold on request
    initial begin
        int n;
        out_stall = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_stall <= 1;
                repeat (3000) @(negedge i_clk);
                hold_req = 0;
                out_stall <= 0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 4);
                out_stall <= 1;
                repeat (n) @(negedge i_clk);
                out_stall <= 0;
            end
        end
    end

    task automatic send_word(input t_in w);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        in_valid <= 1;
        in_word  <= w;
        do @(negedge i_clk); while (!in_taken);
        words_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (700) @(negedge i_clk);
    endtask

    function automatic t_in plant_word(input bit noise);
        t_in w;
        if (noise) begin
            w.supply_temp   = $urandom;
            w.outdoor_temp  = $urandom;
            w.flow_capacity = 31'($urandom);
            w.setpoint      = $urandom;
        end else begin
            w.supply_temp   = $urandom_range(30 * Q, 90 * Q);
            w.outdoor_temp  = $signed($urandom_range(0, 60 * Q)) - 30 * Q;
            w.flow_capacity = 31'($urandom_range(0, 4 * Q));
            w.setpoint      = $urandom_range(15 * Q, 25 * Q);
        end
        return w;
    endfunction

    task automatic load_setting(input int kind);
        case (kind)
            0: begin
                write_reg(REG_PROP, 32'h7fff_ffff);  write_reg(REG_INTEG, 32'h7fff_ffff);
                write_reg(REG_DERIV, 32'h7fff_ffff); write_reg(REG_FILTER, 32'h7fff_ffff);
                write_reg(REG_STEP, 32'h7fff_ffff);  write_reg(REG_LOWER, 32'h8000_0000);
                write_reg(REG_XFER, 32'h7fff_ffff);
            end
            1: begin
                write_reg(REG_PROP, 0);  write_reg(REG_INTEG, 0); write_reg(REG_DERIV, 0);
                write_reg(REG_FILTER, 0); write_reg(REG_STEP, 0); write_reg(REG_LOWER, 0);
                write_reg(REG_XFER, 0);
            end
            2: begin
                // crossed clamp: lower above upper
                write_reg(REG_PROP, 4 * Q); write_reg(REG_STEP, Q / 2);
                write_reg(REG_LOWER, 5 * Q); write_reg(REG_INTEG, Q / 8);
                write_reg(REG_DERIV, Q / 4); write_reg(REG_FILTER, 10 * Q);
                write_reg(REG_XFER, Q);
            end
            3: begin
                // top bits set on unsigned registers, plus the unused address
                write_reg(REG_PROP, 32'h8000_0000 | 2 * Q);
                write_reg(REG_INTEG, 32'h8000_0000 | Q / 16);
                write_reg(REG_DERIV, 32'h8000_0000 | Q / 2);
                write_reg(REG_FILTER, 32'h8000_0000 | 20 * Q);
                write_reg(REG_STEP, 32'h8000_0000 | Q / 4);
                write_reg(REG_LOWER, 32'hffff_0000);
                write_reg(REG_XFER, 32'h8000_0000 | Q);
                write_reg(3'd7, $urandom);
            end
            default: begin
                write_reg(REG_PROP, $urandom_range(0, 8 * Q));
                write_reg(REG_INTEG, $urandom_range(0, Q / 2));
                write_reg(REG_DERIV, $urandom_range(0, Q));
                write_reg(REG_FILTER, $urandom_range(0, 100 * Q));
                write_reg(REG_STEP, $urandom_range(Q / 100, Q));
                write_reg(REG_LOWER, $signed($urandom_range(0, 3 * Q / 2)) - Q);
                write_reg(REG_XFER, $urandom_range(0, 2 * Q));
            end
        endcase
        settings_used++;
    endtask

    initial begin
        t_in w;
        logic [31:0] ext[4];
        in_valid = 0; in_word = '0; i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        gaps_on = 1; hold_req = 0; words_sent = 0; settings_used = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1;

        // field extremes under reset settings, then under full-scale gains
        ext = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff};
        for (int s = 0; s < 2; s++) begin
            for (int k = 0; k < 10; k++) begin
                w.supply_temp   = ext[k % 4];
                w.outdoor_temp  = ext[(k + 1) % 4];
                w.flow_capacity = ext[(k / 2) % 4][30:0];
                w.setpoint      = ext[(k + 3 * (k / 4)) % 4];
                send_word(w);
            end
            drain();
            if (s == 0) load_setting(0);
        end

        for (int ph = 1; ph <= 8; ph++) begin
            if (ph == 8) gaps_on = 0;
            load_setting(ph);
            for (int i = 0; i < 210; i++) begin
                if (ph == 2 && i == 20) hold_req = 1;
                if (ph == 4 && i == 100) drain();
                send_word(plant_word($urandom_range(0, 9) == 0));
            end
            drain();
        end

        $display("sent %0d words over %0d register settings, %0d results checked",
                 words_sent, settings_used, results);
        $display("settings covered full-scale, zero, crossed clamp and high-bit writes");
        if (errors == 0 && pending == 0) begin
            $display("pid_heating_loop_with_thermal_plant_tb passed");
        end else begin
            $display("pid_heating_loop_with_thermal_plant_tb failed");
        end
        $finish;
    end
endmodule
